[hw/rtl/tsm_pkg.sv]
// tsm_pkg: shared widths, constants and types of the triangle SAT / MTV unit.
// No dependencies; compile first.
package tsm_pkg;

	localparam int FIELD_W         = 32;    // coordinate field on the input channel
	localparam int COORD_WIDTH_DEF = 32;    // coordinate bits used, taken from the field LSBs
	localparam int UNIT_W          = 16;    // unit axis component, Q1.15
	localparam int DEPTH_W         = 32;    // overlap depth, unsigned Q16.16
	localparam int AX_LAT          = 31;    // register stages inside the axis unit

	localparam logic [DEPTH_W-1:0] DEPTH_NONE = 32'hFFFF_FFFF;
	localparam logic [UNIT_W-1:0]  UNIT_MAX   = 16'd32767;

	// Unit axis of one edge normal; skip marks a zero-length edge.
	typedef struct packed {
		logic                     skip;
		logic signed [UNIT_W-1:0] ux;
		logic signed [UNIT_W-1:0] uy;
	} tsm_axis_t;

endpackage

[hw/rtl/tsm_if.sv]
// tsm_pair_if and tsm_mtv_if: valid/ready channels of the triangle SAT / MTV unit.
// Depends on tsm_pkg.
interface tsm_pair_if;
	import tsm_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [FIELD_W-1:0] a_x0;
	logic signed [FIELD_W-1:0] a_y0;
	logic signed [FIELD_W-1:0] a_x1;
	logic signed [FIELD_W-1:0] a_y1;
	logic signed [FIELD_W-1:0] a_x2;
	logic signed [FIELD_W-1:0] a_y2;
	logic signed [FIELD_W-1:0] b_x0;
	logic signed [FIELD_W-1:0] b_y0;
	logic signed [FIELD_W-1:0] b_x1;
	logic signed [FIELD_W-1:0] b_y1;
	logic signed [FIELD_W-1:0] b_x2;
	logic signed [FIELD_W-1:0] b_y2;

	modport source (
		output valid, a_x0, a_y0, a_x1, a_y1, a_x2, a_y2,
		       b_x0, b_y0, b_x1, b_y1, b_x2, b_y2,
		input  ready
	);
	modport sink (
		input  valid, a_x0, a_y0, a_x1, a_y1, a_x2, a_y2,
		       b_x0, b_y0, b_x1, b_y1, b_x2, b_y2,
		output ready
	);
endinterface

interface tsm_mtv_if;
	import tsm_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     hit;
	logic [DEPTH_W-1:0]       depth;
	logic signed [UNIT_W-1:0] push_x;
	logic signed [UNIT_W-1:0] push_y;

	modport source (output valid, hit, depth, push_x, push_y, input ready);
	modport sink (input valid, hit, depth, push_x, push_y, output ready);
endinterface

[hw/rtl/tsm_axis.sv]
// tsm_axis: pipelined unit-vector generator for one edge normal (normalize,
// square, digit-by-digit square root, restoring divide). Depends on tsm_pkg.
module tsm_axis #(
	parameter int COORD_WIDTH = tsm_pkg::COORD_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [COORD_WIDTH:0] nx,
	input  logic signed [COORD_WIDTH:0] ny,
	output tsm_pkg::tsm_axis_t        axis
);
	import tsm_pkg::*;

	localparam int W      = COORD_WIDTH;
	localparam int JW     = (W > 30) ? W : 30;
	localparam int SHW    = $clog2(JW);
	localparam int NRM_W  = 30;            // normalized magnitude, top bit at 29
	localparam int SQR_W  = 2 * NRM_W;
	localparam int SQ_W   = 63;
	localparam int SQ_ST  = 16;            // two root digits per stage
	localparam int LEN_W  = 31;
	localparam int NUM_W  = 47;
	localparam int DIV_ST = UNIT_W / 2;    // two quotient bits per stage

	typedef struct packed {
		logic [SQ_W-1:0] v;
		logic [SQ_W-1:0] r;
	} sq_t;

	typedef struct packed {
		logic [NRM_W-1:0] mx;
		logic [NRM_W-1:0] my;
		logic             negx;
		logic             negy;
		logic             skip;
	} sd_t;

	typedef struct packed {
		logic [NUM_W-1:0]  rem;
		logic [UNIT_W-1:0] q;
	} dv_t;

	function automatic logic [SHW-1:0] lead_sh(input logic [JW-1:0] m);
		logic [SHW-1:0] pos;
		pos = '0;
		for (int i = 0; i < JW; i++) begin
			if (m[i]) pos = SHW'(i);
		end
		return SHW'(JW - 1) - pos;
	endfunction

	function automatic sq_t sq_step(input sq_t s, input logic [SQ_W-1:0] b);
		sq_t             o;
		logic [SQ_W-1:0] t;
		t = s.r + b;
		if (s.v >= t) begin
			o.v = s.v - t;
			o.r = (s.r >> 1) + b;
		end else begin
			o.v = s.v;
			o.r = s.r >> 1;
		end
		return o;
	endfunction

	function automatic dv_t dv_step(input dv_t s, input logic [LEN_W-1:0] len, input int j);
		dv_t              o;
		logic [NUM_W-1:0] t;
		t = NUM_W'(len) << j;
		o = s;
		if (s.rem >= t) begin
			o.rem  = s.rem - t;
			o.q[j] = 1'b1;
		end
		return o;
	endfunction

	// stage 1: magnitudes
	logic [W:0]       absx, absy;
	logic [W-1:0]     mx_s1, my_s1;
	logic             negx_s1, negy_s1, skip_s1;

	assign absx = nx[W] ? -nx : nx;
	assign absy = ny[W] ? -ny : ny;

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1   <= absx[W-1:0];
			my_s1   <= absy[W-1:0];
			negx_s1 <= nx[W];
			negy_s1 <= ny[W];
			skip_s1 <= (nx == '0) && (ny == '0);
		end
	end

	// stage 2: leading-one position of the larger magnitude
	logic [W-1:0]   mmax;
	logic [W-1:0]   mx_s2, my_s2;
	logic [SHW-1:0] sh_s2;
	logic           negx_s2, negy_s2, skip_s2;

	assign mmax = (mx_s1 > my_s1) ? mx_s1 : my_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s2   <= mx_s1;
			my_s2   <= my_s1;
			sh_s2   <= lead_sh(JW'(mmax));
			negx_s2 <= negx_s1;
			negy_s2 <= negy_s1;
			skip_s2 <= skip_s1;
		end
	end

	// stage 3: common shift, keep the top 30 bits from the leading one down
	logic [JW-1:0]    jx, jy;
	logic [NRM_W-1:0] mxn_s3, myn_s3;
	logic             negx_s3, negy_s3, skip_s3;

	assign jx = JW'(mx_s2) << sh_s2;
	assign jy = JW'(my_s2) << sh_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			mxn_s3  <= jx[JW-1 -: NRM_W];
			myn_s3  <= jy[JW-1 -: NRM_W];
			negx_s3 <= negx_s2;
			negy_s3 <= negy_s2;
			skip_s3 <= skip_s2;
		end
	end

	// stage 4: squares
	logic [SQR_W-1:0] sqx_s4, sqy_s4;
	sd_t              sd_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s4 <= SQR_W'(mxn_s3) * SQR_W'(mxn_s3);
			sqy_s4 <= SQR_W'(myn_s3) * SQR_W'(myn_s3);
			sd_s4  <= '{mx: mxn_s3, my: myn_s3, negx: negx_s3, negy: negy_s3, skip: skip_s3};
		end
	end

	// stage 5 and the root stages
	sq_t sq_s [SQ_ST+1];
	sd_t sd_s [SQ_ST+1];

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s[0].v <= SQ_W'(sqx_s4) + SQ_W'(sqy_s4);
			sq_s[0].r <= '0;
			sd_s[0]   <= sd_s4;
		end
	end

	for (genvar j = 0; j < SQ_ST; j++) begin : g_root
		localparam int B0 = SQ_W - 1 - 4 * j;
		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[j+1] <= sq_step(sq_step(sq_s[j], SQ_W'(1) << B0), SQ_W'(1) << (B0 - 2));
				sd_s[j+1] <= sd_s[j];
			end
		end
	end

	// divide: load numerators, then two quotient bits per stage
	logic [LEN_W-1:0] len_w;
	dv_t              dvx_s [DIV_ST+1];
	dv_t              dvy_s [DIV_ST+1];
	logic [LEN_W-1:0] len_s [DIV_ST+1];
	sd_t              dsd_s [DIV_ST+1];

	assign len_w = (sq_s[SQ_ST].r[LEN_W-1:0] == '0) ? LEN_W'(1) : sq_s[SQ_ST].r[LEN_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			dvx_s[0].rem <= (NUM_W'(sd_s[SQ_ST].mx) << 15) + NUM_W'(len_w >> 1);
			dvx_s[0].q   <= '0;
			dvy_s[0].rem <= (NUM_W'(sd_s[SQ_ST].my) << 15) + NUM_W'(len_w >> 1);
			dvy_s[0].q   <= '0;
			len_s[0]     <= len_w;
			dsd_s[0]     <= sd_s[SQ_ST];
		end
	end

	for (genvar d = 0; d < DIV_ST; d++) begin : g_div
		localparam int J0 = UNIT_W - 1 - 2 * d;
		always_ff @(posedge clk) begin
			if (en) begin
				dvx_s[d+1] <= dv_step(dv_step(dvx_s[d], len_s[d], J0), len_s[d], J0 - 1);
				dvy_s[d+1] <= dv_step(dv_step(dvy_s[d], len_s[d], J0), len_s[d], J0 - 1);
				len_s[d+1] <= len_s[d];
				dsd_s[d+1] <= dsd_s[d];
			end
		end
	end

	// last stage: saturate, apply the normal's signs
	logic [UNIT_W-1:0] cx, cy;
	tsm_axis_t         axis_s31;

	assign cx = (dvx_s[DIV_ST].q > UNIT_MAX) ? UNIT_MAX : dvx_s[DIV_ST].q;
	assign cy = (dvy_s[DIV_ST].q > UNIT_MAX) ? UNIT_MAX : dvy_s[DIV_ST].q;

	always_ff @(posedge clk) begin
		if (en) begin
			axis_s31.skip <= dsd_s[DIV_ST].skip;
			axis_s31.ux   <= dsd_s[DIV_ST].negx ? -cx : cx;
			axis_s31.uy   <= dsd_s[DIV_ST].negy ? -cy : cy;
		end
	end

	assign axis = axis_s31;

endmodule

[hw/rtl/triangle_sat_mtv_unit.sv]
// triangle_sat_mtv_unit: top level of the 2D triangle separating-axis test with
// minimum translation vector. Depends on tsm_pkg, tsm_if (tsm_pair_if, tsm_mtv_if), tsm_axis.
//
//   channel | modport           | moves per transaction
//   --------+-------------------+----------------------------------------------
//   pair    | tsm_pair_if.sink  | two triangles, 6 vertices, signed Q16.16
//   mtv     | tsm_mtv_if.source | hit flag, depth Q16.16, unit push axis Q1.15
//
// One pair per cycle sustained while mtv takes results; once its pair is accepted,
// a result passes 1 input stage, 31 in the axis units set by the square root and
// divide, 5 projection/compare stages and 1 output register.
// Reset clears only the valid bits; there is no state across transactions.
// A stall on mtv freezes the pipe only when the output register and the last
// stage both hold a result; bubbles keep draining and pair stays ready meanwhile.
module triangle_sat_mtv_unit #(
	parameter int COORD_WIDTH = tsm_pkg::COORD_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	tsm_pair_if.sink  pair,
	tsm_mtv_if.source mtv
);
	import tsm_pkg::*;

	localparam int W    = COORD_WIDTH;
	localparam int XW   = (W > FIELD_W) ? W : FIELD_W;
	localparam int NAX  = 3;                 // edge normals of triangle A
	localparam int NPT  = 6;                 // points 0..2 from A, 3..5 from B
	localparam int PW   = W + UNIT_W;        // one product
	localparam int PJ   = PW + 1;            // projection
	localparam int QDW  = PJ - 14;           // depth before saturation
	localparam int LAST = AX_LAT + 1;        // stage where the unit axes appear
	localparam int EDGE_HEAD [NAX] = '{2, 0, 1};
	localparam int EDGE_TAIL [NAX] = '{0, 1, 2};
	localparam logic [UNIT_W-1:0] UNIT_FULL_NEG = ~UNIT_MAX;

	function automatic logic signed [W-1:0] crd_of(input logic [FIELD_W-1:0] raw);
		logic [XW-1:0] ext;
		ext = XW'(raw);
		return ext[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] cmin3(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b, input logic signed [W-1:0] c);
		logic signed [W-1:0] m;
		m = (b < a) ? b : a;
		return (c < m) ? c : m;
	endfunction

	function automatic logic signed [W-1:0] cmax3(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b, input logic signed [W-1:0] c);
		logic signed [W-1:0] m;
		m = (b > a) ? b : a;
		return (c > m) ? c : m;
	endfunction

	function automatic logic signed [PJ-1:0] pmin3(input logic signed [PJ-1:0] a,
		input logic signed [PJ-1:0] b, input logic signed [PJ-1:0] c);
		logic signed [PJ-1:0] m;
		m = (b < a) ? b : a;
		return (c < m) ? c : m;
	endfunction

	function automatic logic signed [PJ-1:0] pmax3(input logic signed [PJ-1:0] a,
		input logic signed [PJ-1:0] b, input logic signed [PJ-1:0] c);
		logic signed [PJ-1:0] m;
		m = (b > a) ? b : a;
		return (c > m) ? c : m;
	endfunction

	function automatic logic signed [PW-1:0] mul(input logic signed [W-1:0] x,
		input logic signed [UNIT_W-1:0] u);
		return $signed({{UNIT_W{x[W-1]}}, x}) * $signed({{W{u[UNIT_W-1]}}, u});
	endfunction

	// flow control: stall only when a finished result has nowhere to go
	logic en;
	logic out_load;
	logic out_valid_q;
	logic v_s37;

	assign out_load   = !out_valid_q || mtv.ready;
	assign en         = !(v_s37 && out_valid_q && !mtv.ready);
	assign pair.ready = en;

	// input decode
	logic signed [W-1:0] in_x [NPT];
	logic signed [W-1:0] in_y [NPT];

	assign in_x[0] = crd_of(pair.a_x0);
	assign in_y[0] = crd_of(pair.a_y0);
	assign in_x[1] = crd_of(pair.a_x1);
	assign in_y[1] = crd_of(pair.a_y1);
	assign in_x[2] = crd_of(pair.a_x2);
	assign in_y[2] = crd_of(pair.a_y2);
	assign in_x[3] = crd_of(pair.b_x0);
	assign in_y[3] = crd_of(pair.b_y0);
	assign in_x[4] = crd_of(pair.b_x1);
	assign in_y[4] = crd_of(pair.b_y1);
	assign in_x[5] = crd_of(pair.b_x2);
	assign in_y[5] = crd_of(pair.b_y2);

	// stage 1: capture points, edge normals and bounding boxes
	logic                v_s1;
	logic signed [W-1:0] cx_s1 [NPT];
	logic signed [W-1:0] cy_s1 [NPT];
	logic signed [W:0]   nx_s1 [NAX];
	logic signed [W:0]   ny_s1 [NAX];
	logic signed [W-1:0] lox_s1 [2];
	logic signed [W-1:0] hix_s1 [2];
	logic signed [W-1:0] loy_s1 [2];
	logic signed [W-1:0] hiy_s1 [2];

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1 <= in_x;
			cy_s1 <= in_y;
			for (int k = 0; k < NAX; k++) begin
				// normal (-dy, dx) of the edge tail -> head
				nx_s1[k] <= $signed({in_y[EDGE_TAIL[k]][W-1], in_y[EDGE_TAIL[k]]})
				          - $signed({in_y[EDGE_HEAD[k]][W-1], in_y[EDGE_HEAD[k]]});
				ny_s1[k] <= $signed({in_x[EDGE_HEAD[k]][W-1], in_x[EDGE_HEAD[k]]})
				          - $signed({in_x[EDGE_TAIL[k]][W-1], in_x[EDGE_TAIL[k]]});
			end
			for (int t = 0; t < 2; t++) begin
				lox_s1[t] <= cmin3(in_x[3*t], in_x[3*t+1], in_x[3*t+2]);
				hix_s1[t] <= cmax3(in_x[3*t], in_x[3*t+1], in_x[3*t+2]);
				loy_s1[t] <= cmin3(in_y[3*t], in_y[3*t+1], in_y[3*t+2]);
				hiy_s1[t] <= cmax3(in_y[3*t], in_y[3*t+1], in_y[3*t+2]);
			end
		end
	end

	// stages 2..32: hold points and box result while the axis units run
	logic                v_s   [2:LAST];
	logic                bok_s [2:LAST];
	logic signed [W-1:0] cxd_s [2:LAST][NPT];
	logic signed [W-1:0] cyd_s [2:LAST][NPT];

	always_ff @(posedge clk) begin
		if (en) begin
			cxd_s[2] <= cx_s1;
			cyd_s[2] <= cy_s1;
			bok_s[2] <= !(lox_s1[0] > hix_s1[1] || hix_s1[0] < lox_s1[1] ||
			              hiy_s1[0] < loy_s1[1] || loy_s1[0] > hiy_s1[1]);
			for (int i = 3; i <= LAST; i++) begin
				cxd_s[i] <= cxd_s[i-1];
				cyd_s[i] <= cyd_s[i-1];
				bok_s[i] <= bok_s[i-1];
			end
		end
	end

	tsm_axis_t axis_s32 [NAX];

	for (genvar k = 0; k < NAX; k++) begin : g_axis
		tsm_axis #(
			.COORD_WIDTH(W)
		) u_axis (
			.clk  (clk),
			.en   (en),
			.nx   (nx_s1[k]),
			.ny   (ny_s1[k]),
			.axis (axis_s32[k])
		);
	end

	// stage 33: products
	logic                 v_s33, bok_s33;
	tsm_axis_t            ax_s33 [NAX];
	logic signed [PW-1:0] prx_s33 [NAX][NPT];
	logic signed [PW-1:0] pry_s33 [NAX][NPT];

	// stage 34: projections
	logic                 v_s34, bok_s34;
	tsm_axis_t            ax_s34 [NAX];
	logic signed [PJ-1:0] prj_s34 [NAX][NPT];

	// stage 35: intervals
	logic                 v_s35, bok_s35;
	tsm_axis_t            ax_s35 [NAX];
	logic signed [PJ-1:0] loa_s35 [NAX];
	logic signed [PJ-1:0] hia_s35 [NAX];
	logic signed [PJ-1:0] lob_s35 [NAX];
	logic signed [PJ-1:0] hib_s35 [NAX];

	// stage 36: separation and raw depth
	logic                 v_s36, bok_s36;
	tsm_axis_t            ax_s36 [NAX];
	logic                 sep_s36 [NAX];
	logic                 upd_s36 [NAX];
	logic                 neg_s36 [NAX];
	logic [PJ-1:0]        diff_s36 [NAX];

	// stage 37: Q16.16 depth and signed push axis
	logic                     bok_s37;
	logic                     sep_s37 [NAX];
	logic                     upd_s37 [NAX];
	logic [DEPTH_W-1:0]       d_s37 [NAX];
	logic signed [UNIT_W-1:0] pux_s37 [NAX];
	logic signed [UNIT_W-1:0] puy_s37 [NAX];
	logic [QDW-1:0]           qd [NAX];

	always_comb begin
		for (int k = 0; k < NAX; k++) begin
			// drop 15 fraction bits, round half up
			qd[k] = QDW'(diff_s36[k][PJ-1:15]) + QDW'(diff_s36[k][14]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bok_s33 <= bok_s[LAST];
			bok_s34 <= bok_s33;
			bok_s35 <= bok_s34;
			bok_s36 <= bok_s35;
			bok_s37 <= bok_s36;
			for (int k = 0; k < NAX; k++) begin
				ax_s33[k] <= axis_s32[k];
				ax_s34[k] <= ax_s33[k];
				ax_s35[k] <= ax_s34[k];
				ax_s36[k] <= ax_s35[k];
				for (int p = 0; p < NPT; p++) begin
					prx_s33[k][p] <= mul(cxd_s[LAST][p], axis_s32[k].ux);
					pry_s33[k][p] <= mul(cyd_s[LAST][p], axis_s32[k].uy);
					prj_s34[k][p] <= PJ'(prx_s33[k][p]) + PJ'(pry_s33[k][p]);
				end
				loa_s35[k] <= pmin3(prj_s34[k][0], prj_s34[k][1], prj_s34[k][2]);
				hia_s35[k] <= pmax3(prj_s34[k][0], prj_s34[k][1], prj_s34[k][2]);
				lob_s35[k] <= pmin3(prj_s34[k][3], prj_s34[k][4], prj_s34[k][5]);
				hib_s35[k] <= pmax3(prj_s34[k][3], prj_s34[k][4], prj_s34[k][5]);

				// a zero-length edge neither separates nor updates
				sep_s36[k] <= !ax_s35[k].skip &&
				              (loa_s35[k] > hib_s35[k] || hia_s35[k] < lob_s35[k]);
				upd_s36[k] <= !ax_s35[k].skip &&
				              !(loa_s35[k] > hib_s35[k] || hia_s35[k] < lob_s35[k]) &&
				              (hia_s35[k] != hib_s35[k]);
				neg_s36[k] <= hia_s35[k] > hib_s35[k];
				diff_s36[k] <= (hia_s35[k] < hib_s35[k]) ? PJ'(hia_s35[k] - lob_s35[k])
				                                         : PJ'(hib_s35[k] - loa_s35[k]);

				sep_s37[k] <= sep_s36[k];
				upd_s37[k] <= upd_s36[k];
				d_s37[k]   <= (qd[k] > QDW'(DEPTH_NONE)) ? DEPTH_NONE : DEPTH_W'(qd[k]);
				pux_s37[k] <= neg_s36[k] ? -ax_s36[k].ux : ax_s36[k].ux;
				puy_s37[k] <= neg_s36[k] ? -ax_s36[k].uy : ax_s36[k].uy;
			end
		end
	end

	// pick the smallest depth, first edge wins a tie
	logic                     hit_w;
	logic                     sep_any;
	logic [DEPTH_W-1:0]       best;
	logic signed [UNIT_W-1:0] bx, by;

	always_comb begin
		best    = DEPTH_NONE;
		bx      = '0;
		by      = '0;
		sep_any = 1'b0;
		for (int k = 0; k < NAX; k++) begin
			if (upd_s37[k] && (d_s37[k] < best)) begin
				best = d_s37[k];
				bx   = pux_s37[k];
				by   = puy_s37[k];
			end
			sep_any = sep_any | sep_s37[k];
		end
		hit_w = bok_s37 && !sep_any;
	end

	// output register
	logic                     hit_q;
	logic [DEPTH_W-1:0]       depth_q;
	logic signed [UNIT_W-1:0] push_x_q, push_y_q;

	always_ff @(posedge clk) begin
		if (out_load) begin
			hit_q    <= hit_w;
			depth_q  <= hit_w ? best : '0;
			push_x_q <= hit_w ? bx : '0;
			push_y_q <= hit_w ? by : '0;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s         <= '{default: 1'b0};
			v_s33       <= 1'b0;
			v_s34       <= 1'b0;
			v_s35       <= 1'b0;
			v_s36       <= 1'b0;
			v_s37       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en) begin
				v_s1  <= pair.valid;
				v_s[2] <= v_s1;
				for (int i = 3; i <= LAST; i++) begin
					v_s[i] <= v_s[i-1];
				end
				v_s33 <= v_s[LAST];
				v_s34 <= v_s33;
				v_s35 <= v_s34;
				v_s36 <= v_s35;
				v_s37 <= v_s36;
			end
			if (out_load) begin
				out_valid_q <= v_s37;
			end
		end
	end

	assign mtv.valid  = out_valid_q;
	assign mtv.hit    = hit_q;
	assign mtv.depth  = depth_q;
	assign mtv.push_x = push_x_q;
	assign mtv.push_y = push_y_q;

`ifndef ASSERT_OFF
	// a miss carries no depth and no axis
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		mtv.valid && !mtv.hit |-> mtv.depth == '0 && mtv.push_x == '0 && mtv.push_y == '0)
		else $error("miss result with nonzero depth or axis");

	// a hit with no minimum update has a zero axis
	a_none_axis: assert property (@(posedge clk) disable iff (!arst_n)
		mtv.valid && mtv.hit && mtv.depth == DEPTH_NONE |-> mtv.push_x == '0 && mtv.push_y == '0)
		else $error("axis set without a depth update");

	// input backpressure only while a result is held at the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pair.ready |-> mtv.valid && !mtv.ready)
		else $error("pair stalled without output backpressure");

	// unit components saturate at +-32767
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		mtv.valid |-> mtv.push_x != UNIT_FULL_NEG && mtv.push_y != UNIT_FULL_NEG)
		else $error("push axis component out of Q1.15 unit range");
`endif

endmodule
